// ===== src/pchb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pchb_pkg
// Shared types, codes, constants and the palette ROM of the colour binner.
// ----------------------------------------------------------------------------
package pchb_pkg;

    localparam int SIDE_DEF     = 128;
    localparam int ACC_BITS_DEF = 32;
    localparam int PROD_W       = 32;
    localparam int FRAC_SHIFT   = 20;
    localparam int SUM_W        = 32;
    localparam int COL_W        = 9;
    localparam int PAL_SIZE     = 19;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [15:0] BPU_RESET = 16'd6554;
    localparam logic [PADDR_W-3:0] REG_BPU = '0;

    typedef enum logic {
        ACT_ACCUM = 1'b0,
        ACT_READ  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_ACCUM   = 2'd0,
        ST_READ    = 2'd1,
        ST_BAD_PAL = 2'd2
    } t_status;

    typedef struct packed {
        t_action            action;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic [4:0]         palette_index;
        logic [6:0]         cell_row;
        logic [6:0]         cell_col;
        logic               clear_after_read;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic [SUM_W-1:0]   red_sum;
        logic [SUM_W-1:0]   green_sum;
        logic [SUM_W-1:0]   blue_sum;
        logic [SUM_W-1:0]   alpha_sum;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic clr_we;
        logic load_in;
        logic mul_en;
        logic rd_en;
        logic rmw_en;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_stat;

    // index 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [3:0][COL_W-1:0] t_color;

    function automatic t_color pal_color(input logic [4:0] idx);
        t_color c;
        case (idx) inside
            5'd0, 5'd10, 5'd14: c = {9'd256, 9'd0,   9'd128, 9'd256};
            5'd1, 5'd15, 5'd17: c = {9'd256, 9'd256, 9'd0,   9'd0};
            5'd2:               c = {9'd256, 9'd256, 9'd0,   9'd256};
            5'd3, 5'd8:         c = {9'd256, 9'd0,   9'd256, 9'd0};
            5'd4, 5'd7, 5'd11:  c = {9'd256, 9'd0,   9'd0,   9'd256};
            5'd5:               c = {9'd256, 9'd0,   9'd256, 9'd256};
            5'd6:               c = {9'd256, 9'd256, 9'd256, 9'd0};
            5'd9:               c = {9'd256, 9'd256, 9'd128, 9'd0};
            5'd12:              c = {9'd256, 9'd0,   9'd179, 9'd256};
            5'd13:              c = {9'd256, 9'd0,   9'd77,  9'd256};
            5'd16:              c = {9'd256, 9'd256, 9'd0,   9'd51};
            5'd18:              c = {9'd256, 9'd256, 9'd51,  9'd0};
            default:            c = '0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/pchb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pchb_ctrl
// Sequencer: clearing pass after reset, then one word at a time through
// multiply, grid read, read-modify-write and result hand-off.
// ----------------------------------------------------------------------------
module pchb_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire pchb_pkg::t_stat i_stat,
    output pchb_pkg::t_cmd      o_cmd,
    output logic                o_in_stall
);
    import pchb_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MUL   = 6'b000100,
        S_ADDR  = 6'b001000,
        S_RMW   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_RMW;
            end
            S_RMW: begin
                o_cmd.rmw_en = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // hold here while the previous word is still stalled
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_item_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> o_cmd.mul_en ##1 o_cmd.rd_en ##1 o_cmd.rmw_en)
        else $error("item did not step through multiply, read and update");

    a_clear_opens_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_we && i_stat.clr_last |=> !o_in_stall)
        else $error("input not opened after clearing pass");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free && !o_cmd.clr_we)
        else $error("result loaded into an occupied output register");

endmodule
`default_nettype wire

// ===== src/pchb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pchb_datapath
// Coordinate scaling, bin clamping, grid memory with saturating update,
// and the output register.
// ----------------------------------------------------------------------------
module pchb_datapath #(
    parameter int SIDE     = pchb_pkg::SIDE_DEF,
    parameter int ACC_BITS = pchb_pkg::ACC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pchb_pkg::t_cmd     i_cmd,
    output pchb_pkg::t_stat         o_stat,
    input  wire pchb_pkg::t_in_word i_in_word,
    input  wire logic [15:0]        i_bins_per_unit,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output pchb_pkg::t_out_word     o_out_word
);
    import pchb_pkg::*;

    localparam int CW    = $clog2(SIDE);
    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int HALF  = SIDE / 2;
    localparam int SW    = (CW + 2 > 14) ? CW + 2 : 14;

    localparam logic [AW-1:0]        SIDE_A  = AW'(SIDE);
    localparam logic [AW-1:0]        LAST_A  = AW'(DEPTH - 1);
    localparam logic [CW-1:0]        MAX_BIN = CW'(SIDE - 1);
    localparam logic signed [SW-1:0] HALF_S  = SW'(HALF);
    localparam logic signed [SW-1:0] HALF_M1 = SW'(HALF - 1);
    localparam logic [ACC_BITS-1:0]  ACC_MAX = '1;

    typedef logic [3:0][ACC_BITS-1:0] t_sums;

    // truncate toward zero, clamp above at half side, offset, clamp at zero
    function automatic logic [CW-1:0] to_bin(input logic signed [PROD_W-1:0] prod);
        logic [PROD_W-1:0]   mag;
        logic signed [SW-1:0] b;
        mag = prod[PROD_W-1] ? PROD_W'(-prod) : prod;
        b   = SW'(mag[PROD_W-1:FRAC_SHIFT]);
        if (prod[PROD_W-1]) begin
            b = -b;
        end
        if (b > HALF_S) begin
            b = HALF_S;
        end
        b = b + HALF_M1;
        if (b[SW-1]) begin
            b = '0;
        end
        return b[CW-1:0];
    endfunction

    t_in_word               r_item;
    logic signed [PROD_W-1:0] r_prod_x;
    logic signed [PROD_W-1:0] r_prod_y;
    logic [AW-1:0]          r_addr;
    logic                   r_in_range;
    t_sums                  r_rd_data;
    logic [AW-1:0]          r_clr_addr;
    t_out_word              r_res;
    logic                   r_out_valid;
    t_out_word              r_out_word;

    t_sums                  r_mem [DEPTH];

    logic signed [PROD_W-1:0] x_ext;
    logic signed [PROD_W-1:0] y_ext;
    logic signed [PROD_W-1:0] k_ext;
    logic [CW-1:0]          x_bin;
    logic [CW-1:0]          y_bin;
    logic                   in_range;
    logic [AW-1:0]          rd_addr;
    logic                   is_read;
    logic                   bad_pal;
    t_color                 color;
    logic [ACC_BITS:0]      sum_ext [4];
    t_sums                  new_sums;
    logic                   wr_hit;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    t_sums                  mem_wdata;
    t_out_word              res_word;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_in_word;
        end
    end

    // scale both coordinates, Q4.12 times Q8.8 gives Q.20
    assign x_ext = PROD_W'(r_item.point_x);
    assign y_ext = PROD_W'(r_item.point_y);
    assign k_ext = PROD_W'(i_bins_per_unit);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod_x <= x_ext * k_ext;
            r_prod_y <= y_ext * k_ext;
        end
    end

    // cell address
    assign x_bin    = to_bin(r_prod_x);
    assign y_bin    = to_bin(r_prod_y);
    assign is_read  = (r_item.action == ACT_READ);
    assign in_range = (32'(r_item.cell_row) < 32'(SIDE)) &&
                      (32'(r_item.cell_col) < 32'(SIDE));
    assign rd_addr  = is_read ?
                      AW'(r_item.cell_row) * SIDE_A + AW'(r_item.cell_col) :
                      AW'(x_bin) * SIDE_A + AW'(y_bin);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_addr     <= rd_addr;
            r_in_range <= in_range;
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // saturating update
    assign bad_pal = (r_item.palette_index >= 5'(PAL_SIZE));
    assign color   = pal_color(r_item.palette_index);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sum_ext[k]  = {1'b0, r_rd_data[k]} + (ACC_BITS + 1)'(color[k]);
            new_sums[k] = sum_ext[k][ACC_BITS] ? ACC_MAX : sum_ext[k][ACC_BITS-1:0];
        end
    end

    assign wr_hit    = is_read ? (r_item.clear_after_read && r_in_range) : !bad_pal;
    assign mem_we    = i_cmd.clr_we || (i_cmd.rmw_en && wr_hit);
    assign mem_waddr = i_cmd.clr_we ? r_clr_addr : r_addr;
    assign mem_wdata = (i_cmd.clr_we || is_read) ? '0 : new_sums;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // result word
    always_comb begin
        res_word = '0;
        if (is_read) begin
            res_word.status = ST_READ;
            if (r_in_range) begin
                res_word.red_sum   = SUM_W'(r_rd_data[0]);
                res_word.green_sum = SUM_W'(r_rd_data[1]);
                res_word.blue_sum  = SUM_W'(r_rd_data[2]);
                res_word.alpha_sum = SUM_W'(r_rd_data[3]);
            end
        end else if (bad_pal) begin
            res_word.status = ST_BAD_PAL;
        end else begin
            res_word.status = ST_ACCUM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rmw_en) begin
            r_res <= res_word;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_word <= r_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_out_word;
    assign o_stat.clr_last = (r_clr_addr == LAST_A);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(i_cmd))
        else $error("more than one datapath command at once");

    a_bins_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en && !is_read |-> (x_bin <= MAX_BIN) && (y_bin <= MAX_BIN))
        else $error("clamped bin outside the grid");

    a_result_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_out_valid && (o_out_word.status == $past(r_res.status)))
        else $error("result not presented after load");

endmodule
`default_nettype wire

// ===== src/point_color_histogram_binner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_color_histogram_binner
// Bins points into a SIDE x SIDE grid of saturating RGBA sums and reads cells.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries one word: an accumulate
// (scaled, clamped x and y bins plus a palette colour added into the cell)
// or a read of one cell with optional clear. Every word gives exactly one
// result word on o_out_valid / i_out_stall.
// The sequencer steps one word at a time through multiply, grid read,
// read-modify-write and output load, and takes no new word until the last
// has been loaded into the output register; the grid memory has a single
// read and a single write port.
// Reset: the grid is zeroed by a clearing pass over all SIDE*SIDE cells,
// during which o_in_stall stays high; bins_per_unit returns
// to 6554. Configuration writes are taken at any time over the APB port.
// A stalled result is held in the output register; the next input word is
// still taken and waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module point_color_histogram_binner #(
    parameter int SIDE     = pchb_pkg::SIDE_DEF,
    parameter int ACC_BITS = pchb_pkg::ACC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire pchb_pkg::t_in_word             i_in_word,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output pchb_pkg::t_out_word                 o_out_word,
    input  wire logic                           i_out_stall,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pchb_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [pchb_pkg::PDATA_W-1:0]   pwdata,
    output logic [pchb_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import pchb_pkg::*;

    logic [15:0] r_bpu;
    logic        reg_sel;
    t_cmd        cmd;
    t_stat       stat;

    // register file
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_BPU);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? PDATA_W'(r_bpu) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpu <= BPU_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_bpu <= pwdata[15:0];
        end
    end

    pchb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    pchb_datapath #(
        .SIDE     (SIDE),
        .ACC_BITS (ACC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_in_word       (i_in_word),
        .i_bins_per_unit (r_bpu),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_word      (o_out_word)
    );

endmodule
`default_nettype wire

// ===== tb/tb_point_color_histogram_binner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_color_histogram_binner
// Self-checking bench for the colour histogram binner. A short directed table
// is followed by random words over several bins_per_unit settings. An in-bench
// model of the grid predicts each result word but for typed directed words, which
// expect their status with zero sums. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_point_color_histogram_binner;
    import pchb_pkg::*;

    localparam int GRID_SIDE  = SIDE_DEF;
    localparam int HALF_SIDE  = GRID_SIDE / 2;
    localparam int CELLS      = GRID_SIDE * GRID_SIDE;
    localparam int SETTLE     = 12;
    localparam int PHASES     = 6;
    localparam int PER_PHASE  = 155;
    localparam int MAX_CYCLES = 600000;
    localparam logic [PADDR_W-1:0] SCALE_ADDR = {REG_BPU, 2'b00};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    t_in_word i_in_word;
    logic o_in_stall;
    logic o_out_valid;
    t_out_word o_out_word;
    logic i_out_stall;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    point_color_histogram_binner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    typedef struct {
        t_in_word word;
        bit       typed;
        t_status  status;
    } t_vector;

    // colour sums per cell: 0 red, 1 green, 2 blue, 3 alpha
    logic [31:0]  grid_sums [0:CELLS-1][0:3];
    logic [15:0]  bins_scale;
    logic [15:0]  coord_pool [0:7];
    logic [13:0]  hit_cells [$];
    t_out_word    pending_results [$];
    t_vector      vectors [$];
    t_out_word    due_word;
    int           fail_count = 0;
    int           calm_left = 0;
    int           cycle_count = 0;

    // palette as {red, green, blue, alpha}, 256 = 1.0
    function automatic logic [35:0] palette_rgba(input logic [4:0] idx);
        case (idx)
            5'd0, 5'd10, 5'd14: return {9'd256, 9'd128, 9'd0,   9'd256};
            5'd1, 5'd15, 5'd17: return {9'd0,   9'd0,   9'd256, 9'd256};
            5'd2:               return {9'd256, 9'd0,   9'd256, 9'd256};
            5'd3, 5'd8:         return {9'd0,   9'd256, 9'd0,   9'd256};
            5'd4, 5'd7, 5'd11:  return {9'd256, 9'd0,   9'd0,   9'd256};
            5'd5:               return {9'd256, 9'd256, 9'd0,   9'd256};
            5'd6:               return {9'd0,   9'd256, 9'd256, 9'd256};
            5'd9:               return {9'd0,   9'd128, 9'd256, 9'd256};
            5'd12:              return {9'd256, 9'd179, 9'd0,   9'd256};
            5'd13:              return {9'd256, 9'd77,  9'd0,   9'd256};
            5'd16:              return {9'd51,  9'd0,   9'd256, 9'd256};
            5'd18:              return {9'd0,   9'd51,  9'd256, 9'd256};
            default:            return '0;
        endcase
    endfunction

    // scale, truncate toward zero, clamp above, offset, clamp below
    function automatic int coord_bin(input logic signed [15:0] coord,
                                     input logic [15:0] scale);
        longint prod;
        longint mag;
        longint b;
        prod = longint'(coord) * longint'(scale);
        mag = (prod < 0) ? -prod : prod;
        b = mag >> FRAC_SHIFT;
        if (prod < 0) begin
            b = -b;
        end
        if (b > HALF_SIDE) begin
            b = HALF_SIDE;
        end
        b = b + HALF_SIDE - 1;
        if (b < 0) begin
            b = 0;
        end
        return int'(b);
    endfunction

    // expected result word, updating the grid copy as the block would
    function automatic t_out_word histogram_response(input t_in_word w);
        t_out_word r;
        logic [35:0] rgba;
        logic [32:0] total;
        int xb;
        int yb;
        int cell_idx;
        r = '0;
        if (w.action == ACT_ACCUM) begin
            if (w.palette_index >= PAL_SIZE) begin
                r.status = ST_BAD_PAL;
            end else begin
                r.status = ST_ACCUM;
                rgba = palette_rgba(w.palette_index);
                xb = coord_bin(w.point_x, bins_scale);
                yb = coord_bin(w.point_y, bins_scale);
                cell_idx = xb * GRID_SIDE + yb;
                for (int ch = 0; ch < 4; ch++) begin
                    total = {1'b0, grid_sums[cell_idx][ch]} + {24'b0, rgba[35 - 9*ch -: 9]};
                    grid_sums[cell_idx][ch] = total[32] ? 32'hFFFF_FFFF : total[31:0];
                end
                hit_cells.insert(hit_cells.size(), cell_idx[13:0]);
                if (hit_cells.size() > 24) begin
                    void'(hit_cells.pop_front());
                end
            end
        end else begin
            r.status = ST_READ;
            cell_idx = int'(w.cell_row) * GRID_SIDE + int'(w.cell_col);
            r.red_sum   = grid_sums[cell_idx][0];
            r.green_sum = grid_sums[cell_idx][1];
            r.blue_sum  = grid_sums[cell_idx][2];
            r.alpha_sum = grid_sums[cell_idx][3];
            if (w.clear_after_read) begin
                for (int ch = 0; ch < 4; ch++) begin
                    grid_sums[cell_idx][ch] = '0;
                end
            end
        end
        return r;
    endfunction

    function automatic t_out_word plain_result(input t_status st);
        t_out_word r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic t_in_word make_word(input t_action act, input logic [15:0] x,
                                           input logic [15:0] y, input logic [4:0] pal,
                                           input logic [6:0] row, input logic [6:0] col,
                                           input logic clr);
        t_in_word w;
        w.action = act;
        w.point_x = x;
        w.point_y = y;
        w.palette_index = pal;
        w.cell_row = row;
        w.cell_col = col;
        w.clear_after_read = clr;
        return w;
    endfunction

    function automatic logic [15:0] pick_coord();
        logic [31:0] r;
        int sel;
        sel = $urandom_range(0, 99);
        r = $urandom;
        if (sel < 55) begin
            return coord_pool[r[2:0]];
        end
        if (sel < 85) begin
            return {{3{r[12]}}, r[12:0]};
        end
        return r[15:0];
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        logic [31:0] r1;
        logic [31:0] r2;
        logic [31:0] pal;
        logic [13:0] hit_idx;
        r1 = $urandom;
        r2 = $urandom;
        // unused fields carry noise
        w = make_word(ACT_ACCUM, r1[15:0], r1[31:16], r2[4:0], r2[11:5], r2[18:12], r2[19]);
        if ($urandom_range(0, 99) < 30) begin
            w.action = ACT_READ;
            if (hit_cells.size() > 0 && $urandom_range(0, 99) < 70) begin
                hit_idx = hit_cells[$urandom_range(0, hit_cells.size() - 1)];
                w.cell_row = hit_idx[13:7];
                w.cell_col = hit_idx[6:0];
            end
            w.clear_after_read = ($urandom_range(0, 3) == 0);
        end else begin
            if ($urandom_range(0, 99) < 90) begin
                pal = $urandom_range(0, PAL_SIZE - 1);
                w.palette_index = pal[4:0];
            end else begin
                pal = $urandom_range(PAL_SIZE, 31);
                w.palette_index = pal[4:0];
            end
            w.point_x = pick_coord();
            w.point_y = pick_coord();
        end
        return w;
    endfunction

    task automatic add_vector(input t_in_word w, input bit typed, input t_status st);
        t_vector v;
        v.word = w;
        v.typed = typed;
        v.status = st;
        vectors.insert(vectors.size(), v);
    endtask

    task automatic load_vectors();
        // empty grid after reset, point fields ignored on a read
        add_vector(make_word(ACT_READ, 16'h0000, 16'h0000, 5'd0, 7'd0, 7'd0, 1'b0),
                   1, ST_READ);
        add_vector(make_word(ACT_READ, 16'h8000, 16'h7FFF, 5'd31, 7'd127, 7'd127, 1'b1),
                   1, ST_READ);
        // cell fields ignored on an accumulate
        add_vector(make_word(ACT_ACCUM, 16'h0000, 16'h0000, 5'd0, 7'd127, 7'd127, 1'b1),
                   1, ST_ACCUM);
        add_vector(make_word(ACT_ACCUM, 16'h0000, 16'h0000, 5'd18, 7'd0, 7'd0, 1'b0),
                   1, ST_ACCUM);
        // coordinate extremes land in the corners
        add_vector(make_word(ACT_ACCUM, 16'h7FFF, 16'h7FFF, 5'd12, 7'd0, 7'd0, 1'b0),
                   1, ST_ACCUM);
        add_vector(make_word(ACT_ACCUM, 16'h8000, 16'h8000, 5'd13, 7'd0, 7'd0, 1'b0),
                   1, ST_ACCUM);
        add_vector(make_word(ACT_ACCUM, 16'h7FFF, 16'h8000, 5'd16, 7'd0, 7'd0, 1'b0),
                   1, ST_ACCUM);
        add_vector(make_word(ACT_ACCUM, 16'h8000, 16'h7FFF, 5'd9, 7'd0, 7'd0, 1'b0),
                   1, ST_ACCUM);
        // bad palette entries add nothing
        add_vector(make_word(ACT_ACCUM, 16'h0000, 16'h0000, 5'd19, 7'd0, 7'd0, 1'b0),
                   1, ST_BAD_PAL);
        add_vector(make_word(ACT_ACCUM, 16'h7FFF, 16'h8000, 5'd31, 7'd63, 7'd63, 1'b1),
                   1, ST_BAD_PAL);
        // small negatives truncate toward zero, not down
        add_vector(make_word(ACT_ACCUM, 16'hFFFF, 16'h0001, 5'd1, 7'd0, 7'd0, 1'b0),
                   1, ST_ACCUM);
        add_vector(make_word(ACT_ACCUM, 16'hFF60, 16'h00A0, 5'd2, 7'd0, 7'd0, 1'b0),
                   1, ST_ACCUM);
        add_vector(make_word(ACT_READ, 16'h1234, 16'h8765, 5'd7, 7'd63, 7'd63, 1'b0),
                   0, ST_READ);
        add_vector(make_word(ACT_READ, 16'h0000, 16'h0000, 5'd0, 7'd127, 7'd127, 1'b0),
                   0, ST_READ);
        add_vector(make_word(ACT_READ, 16'h0000, 16'h0000, 5'd0, 7'd0, 7'd0, 1'b0),
                   0, ST_READ);
        // read with clear, then the cleared cell again
        add_vector(make_word(ACT_READ, 16'h0000, 16'h0000, 5'd0, 7'd127, 7'd0, 1'b1),
                   0, ST_READ);
        add_vector(make_word(ACT_READ, 16'h0000, 16'h0000, 5'd0, 7'd127, 7'd0, 1'b0),
                   0, ST_READ);
        add_vector(make_word(ACT_READ, 16'h0000, 16'h0000, 5'd0, 7'd0, 7'd127, 1'b1),
                   0, ST_READ);
        add_vector(make_word(ACT_READ, 16'h0000, 16'h0000, 5'd0, 7'd62, 7'd64, 1'b0),
                   0, ST_READ);
        add_vector(make_word(ACT_READ, 16'h0000, 16'h0000, 5'd0, 7'd63, 7'd63, 1'b1),
                   0, ST_READ);
        add_vector(make_word(ACT_READ, 16'h0000, 16'h0000, 5'd0, 7'd63, 7'd63, 1'b0),
                   0, ST_READ);
    endtask

    task automatic push_word(input t_in_word w, input bit typed, input t_status st);
        t_out_word due;
        int gap;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        due = histogram_response(w);
        if (typed) begin
            due = plain_result(st);
        end
        pending_results.insert(pending_results.size(), due);
        if (calm_left > 0) begin
            calm_left--;
        end else if ($urandom_range(0, 99) < 5) begin
            calm_left = $urandom_range(10, 40);
        end
        gap = 0;
        if (calm_left == 0 && $urandom_range(0, 99) < 50) begin
            gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4)
                                                : $urandom_range(10, 50);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every result word is back, then let the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= SCALE_ADDR;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_scale(input logic [15:0] want);
        logic [31:0] rd;
        apb_xfer(1'b0, 32'h0, rd);
        if (rd[15:0] !== want) begin
            fail_count++;
            $display("%0t: bins_per_unit read back, expected %0d, got %0d",
                     $time, want, rd[15:0]);
        end
    endtask

    task automatic set_scale(input logic [15:0] value);
        logic [31:0] rd;
        drain();
        apb_xfer(1'b1, {16'h0, value}, rd);
        bins_scale = value;
        check_scale(value);
    endtask

    task automatic refill_pool();
        logic [31:0] r;
        for (int i = 0; i < 8; i++) begin
            r = $urandom;
            coord_pool[i] = {{4{r[11]}}, r[11:0]};
        end
    endtask

    initial begin
        logic [31:0] r;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        for (int c = 0; c < CELLS; c++) begin
            for (int ch = 0; ch < 4; ch++) begin
                grid_sums[c][ch] = '0;
            end
        end
        bins_scale = BPU_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_scale(BPU_RESET);

        load_vectors();
        foreach (vectors[i]) begin
            push_word(vectors[i].word, vectors[i].typed, vectors[i].status);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            r = $urandom_range(1, 65534);
            case (phase)
                1: set_scale(16'h0000);
                2: set_scale(16'hFFFF);
                3: set_scale(16'h0100);
                4: set_scale(r[15:0]);
                5: set_scale(BPU_RESET);
                default: ;
            endcase
            refill_pool();
            repeat (PER_PHASE) push_word(random_word(), 1'b0, ST_ACCUM);
        end

        drain();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // result side backpressure: short stalls, long stalls and clear stretches
    initial begin
        int pick;
        int len;
        logic lvl;
        forever begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                lvl = 1'b0;
                len = $urandom_range(1, 12);
            end else if (pick < 82) begin
                lvl = 1'b1;
                len = $urandom_range(1, 4);
            end else if (pick < 94) begin
                lvl = 1'b0;
                len = $urandom_range(30, 80);
            end else begin
                lvl = 1'b1;
                len = $urandom_range(15, 60);
            end
            i_out_stall <= lvl;
            repeat (len) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: expected no result word, got status %0d", $time,
                         o_out_word.status);
            end else begin
                due_word = pending_results.pop_front();
                if (o_out_word.status !== due_word.status
                        || o_out_word.red_sum !== due_word.red_sum
                        || o_out_word.green_sum !== due_word.green_sum
                        || o_out_word.blue_sum !== due_word.blue_sum
                        || o_out_word.alpha_sum !== due_word.alpha_sum) begin
                    fail_count++;
                    $display("%0t: expected st %0d rgba %h %h %h %h, got st %0d rgba %h %h %h %h",
                             $time, due_word.status, due_word.red_sum,
                             due_word.green_sum, due_word.blue_sum,
                             due_word.alpha_sum, o_out_word.status,
                             o_out_word.red_sum, o_out_word.green_sum,
                             o_out_word.blue_sum, o_out_word.alpha_sum);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES) begin
            $display("%0t: timeout with %0d result words outstanding", $time,
                     pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
